FILE: rtl/jhmp_pkg.sv
// Shared types and constants for the JPEG header marker parser.
// No dependencies; compile first.
package jhmp_pkg;

  // Marker bytes
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;
  localparam logic [7:0] MARK_DQT    = 8'hDB;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_APP0   = 8'hE0;

  // Result kinds
  localparam logic [3:0] KIND_QUANT       = 4'd0;
  localparam logic [3:0] KIND_HEIGHT      = 4'd1;
  localparam logic [3:0] KIND_WIDTH       = 4'd2;
  localparam logic [3:0] KIND_FRAME_COUNT = 4'd3;
  localparam logic [3:0] KIND_FRAME_COMP  = 4'd4;
  localparam logic [3:0] KIND_HUFF_COUNT  = 4'd5;
  localparam logic [3:0] KIND_HUFF_SYMBOL = 4'd6;
  localparam logic [3:0] KIND_HUFF_DONE   = 4'd7;
  localparam logic [3:0] KIND_SCAN_COUNT  = 4'd8;
  localparam logic [3:0] KIND_SCAN_COMP   = 4'd9;
  localparam logic [3:0] KIND_HEADER_DONE = 4'd10;
  localparam logic [3:0] KIND_ERROR       = 4'd11;

  // Error codes
  localparam logic [1:0] ERR_SOF_MODE = 2'd0;
  localparam logic [1:0] ERR_JFIF     = 2'd1;
  localparam logic [1:0] ERR_DHT_LEN  = 2'd2;

  // DQT length / 65 by reciprocal, kept to 8 bits: exact while the quotient fits 8 bits
  localparam int unsigned DQT_DIV_SHIFT = 23;
  localparam logic [16:0] DQT_RECIP     = 17'd129056;

  // Registered byte between the input stage and the parser core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } jhmp_stage_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        table_class;
    logic [3:0]  table_index;
    logic [11:0] position;
    logic [15:0] value;
    logic [7:0]  comp_id;
    logic [3:0]  factor_h;
    logic [3:0]  factor_v;
    logic [7:0]  quant_select;
    logic [3:0]  dc_table;
    logic [3:0]  ac_table;
    logic [1:0]  error_code;
  } jhmp_result_t;

endpackage

FILE: rtl/jhmp_if.sv
// Valid/ready channel interfaces: header byte stream and parse results.
// No dependencies.
interface jhmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface jhmp_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic        table_class;
  logic [3:0]  table_index;
  logic [11:0] position;
  logic [15:0] value;
  logic [7:0]  comp_id;
  logic [3:0]  factor_h;
  logic [3:0]  factor_v;
  logic [7:0]  quant_select;
  logic [3:0]  dc_table;
  logic [3:0]  ac_table;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output table_class, output table_index,
                  output position, output value, output comp_id, output factor_h,
                  output factor_v, output quant_select, output dc_table,
                  output ac_table, output error_code, input ready);
  modport sink   (input valid, input kind, input table_class, input table_index,
                  input position, input value, input comp_id, input factor_h,
                  input factor_v, input quant_select, input dc_table,
                  input ac_table, input error_code, output ready);
endinterface

FILE: rtl/jpeg_header_marker_parser.sv
// Top level of the JPEG header marker parser: input byte register and parser core.
// Depends on jhmp_pkg, jhmp_if, jhmp_in_stage and jhmp_core.
//
//   channel  modport  handshake      payload
//   header   sink     valid/ready    data_byte[7:0]
//   result   source   valid/ready    kind, table fields, position, value, component fields
//
// One byte per cycle unless a result stalls; a byte passes input then result register.
// The state machine steps once per byte between the input register and the result register.
// Reset (rst, synchronous) returns to hunting for 0xFF and clears the halt flag.
// A stalled result holds the core only when the next byte would also give a result.
// After an error or the end of SOS every byte is taken and dropped until reset.
module jpeg_header_marker_parser (
  input logic           clk,
  input logic           rst,
  jhmp_byte_if.sink     header,
  jhmp_result_if.source result
);
  import jhmp_pkg::*;

  jhmp_stage_t stage;
  logic        advance;

  jhmp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .header  (header),
    .advance (advance),
    .stage   (stage)
  );

  jhmp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

endmodule

FILE: rtl/jhmp_in_stage.sv
// Input register for header bytes.
// Depends on jhmp_pkg and jhmp_byte_if.
module jhmp_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  jhmp_byte_if.sink            header,
  input  logic                 advance,
  output jhmp_pkg::jhmp_stage_t stage
);
  import jhmp_pkg::*;

  assign header.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (header.valid && header.ready) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (header.valid && header.ready) begin
      stage.data <= header.data_byte;
    end
  end

endmodule

FILE: rtl/jhmp_core.sv
// Marker parser state machine and result register.
// Depends on jhmp_pkg and jhmp_result_if.
module jhmp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  jhmp_pkg::jhmp_stage_t stage,
  output logic                  advance,
  jhmp_result_if.source         result
);
  import jhmp_pkg::*;

  localparam logic [4:0] PH_SCAN      = 5'd0;
  localparam logic [4:0] PH_MARKER    = 5'd1;
  localparam logic [4:0] PH_APP_SKIP  = 5'd2;
  localparam logic [4:0] PH_APP_TEXT  = 5'd3;
  localparam logic [4:0] PH_DQT_LEN   = 5'd4;
  localparam logic [4:0] PH_DQT_HEAD  = 5'd5;
  localparam logic [4:0] PH_DQT_ENTRY = 5'd6;
  localparam logic [4:0] PH_SOF_SKIP  = 5'd7;
  localparam logic [4:0] PH_SOF_H     = 5'd8;
  localparam logic [4:0] PH_SOF_W     = 5'd9;
  localparam logic [4:0] PH_SOF_COUNT = 5'd10;
  localparam logic [4:0] PH_SOF_COMP  = 5'd11;
  localparam logic [4:0] PH_DHT_LEN   = 5'd12;
  localparam logic [4:0] PH_DHT_HEAD  = 5'd13;
  localparam logic [4:0] PH_DHT_COUNT = 5'd14;
  localparam logic [4:0] PH_DHT_SYM   = 5'd15;
  localparam logic [4:0] PH_DHT_END   = 5'd16;
  localparam logic [4:0] PH_SOS_LEN   = 5'd17;
  localparam logic [4:0] PH_SOS_COUNT = 5'd18;
  localparam logic [4:0] PH_SOS_COMP  = 5'd19;
  localparam logic [4:0] PH_SOS_TAIL  = 5'd20;
  localparam logic [4:0] PH_DONE      = 5'd21;

  localparam logic [11:0] LEN_BYTES   = 12'd2;
  localparam logic [11:0] JFIF_BYTES  = 12'd5;
  localparam logic [11:0] SOF_SKIP    = 12'd3;
  localparam logic [11:0] QUANT_SIZE  = 12'd64;
  localparam logic [11:0] HUFF_COUNTS = 12'd16;
  localparam logic [11:0] SOS_TAIL    = 12'd3;
  localparam logic [16:0] DHT_FIXED   = 17'd19;

  function automatic logic [7:0] jfif_char(input logic [2:0] i);
    case (i)
      3'd0:    jfif_char = 8'h4A;
      3'd1:    jfif_char = 8'h46;
      3'd2:    jfif_char = 8'h49;
      3'd3:    jfif_char = 8'h46;
      default: jfif_char = 8'h00;
    endcase
  endfunction

  // SOF1..SOF15 except DHT, JPG and DAC
  function automatic logic other_sof(input logic [7:0] b);
    other_sof = (b[7:4] == MARK_SOF0[7:4]) && (b != MARK_SOF0) && (b != MARK_DHT)
                && (b != MARK_JPG) && (b != MARK_DAC);
  endfunction

  logic [4:0]   phase, phase_next;
  logic [15:0]  len, len_next;
  logic [11:0]  cnt, cnt_next;
  logic [7:0]   tables, tables_next;
  logic [3:0]   idx, idx_next;
  logic         cls, cls_next;
  logic [11:0]  sym, sym_next;
  logic [7:0]   ctot, ctot_next;
  logic [7:0]   ccnt, ccnt_next;
  logic [15:0]  held, held_next;
  logic         halted, halted_next;

  jhmp_result_t res_c, res_q;
  logic         res_v;
  logic         out_valid;

  logic [7:0]   b;
  logic [15:0]  len_shift;
  logic [11:0]  cnt_inc;
  logic [7:0]   ccnt_inc;
  logic [7:0]   tables_dec;
  logic [11:0]  sym_sum;
  logic [32:0]  dqt_prod;
  logic [7:0]   dqt_tables;

  assign b          = stage.data;
  assign len_shift  = {len[7:0], b};
  assign cnt_inc    = cnt + 12'd1;
  assign ccnt_inc   = ccnt + 8'd1;
  assign tables_dec = tables - 8'd1;
  assign sym_sum    = sym + {4'd0, b};
  assign dqt_prod   = {17'd0, len_shift} * {16'd0, DQT_RECIP};
  assign dqt_tables = dqt_prod[DQT_DIV_SHIFT +: 8];

  always_comb begin
    phase_next  = phase;
    len_next    = len;
    cnt_next    = cnt;
    tables_next = tables;
    idx_next    = idx;
    cls_next    = cls;
    sym_next    = sym;
    ctot_next   = ctot;
    ccnt_next   = ccnt;
    held_next   = held;
    halted_next = halted;
    res_c       = '0;
    res_v       = 1'b0;
    if (!halted && phase != PH_DONE) begin
      case (phase)
        PH_SCAN: begin
          if (b == MARK_PREFIX) phase_next = PH_MARKER;
        end
        PH_MARKER: begin
          cnt_next = '0;
          len_next = '0;
          if (other_sof(b)) begin
            res_c.kind       = KIND_ERROR;
            res_c.value      = {12'd0, b[3:0]};
            res_c.error_code = ERR_SOF_MODE;
            res_v            = 1'b1;
            halted_next      = 1'b1;
          end else begin
            case (b)
              MARK_APP0: phase_next = PH_APP_SKIP;
              MARK_DQT:  phase_next = PH_DQT_LEN;
              MARK_SOF0: phase_next = PH_SOF_SKIP;
              MARK_DHT:  phase_next = PH_DHT_LEN;
              MARK_SOS:  phase_next = PH_SOS_LEN;
              default:   phase_next = PH_SCAN;   // SOI and unknown markers
            endcase
          end
        end
        PH_APP_SKIP: begin
          cnt_next = cnt_inc;
          if (cnt_inc >= LEN_BYTES) begin
            cnt_next   = '0;
            phase_next = PH_APP_TEXT;
          end
        end
        PH_APP_TEXT: begin
          if (b != jfif_char(cnt[2:0])) begin
            res_c.kind       = KIND_ERROR;
            res_c.error_code = ERR_JFIF;
            res_v            = 1'b1;
            halted_next      = 1'b1;
          end else begin
            cnt_next = cnt_inc;
            if (cnt_inc >= JFIF_BYTES) phase_next = PH_SCAN;
          end
        end
        PH_DQT_LEN: begin
          len_next = len_shift;
          cnt_next = cnt_inc;
          if (cnt_inc >= LEN_BYTES) begin
            tables_next = dqt_tables;
            phase_next  = (dqt_tables != 8'd0) ? PH_DQT_HEAD : PH_SCAN;
          end
        end
        PH_DQT_HEAD: begin
          idx_next   = b[3:0];
          cnt_next   = '0;
          phase_next = PH_DQT_ENTRY;
        end
        PH_DQT_ENTRY: begin
          res_c.kind        = KIND_QUANT;
          res_c.table_index = idx;
          res_c.position    = cnt;
          res_c.value       = {8'd0, b};
          res_v             = 1'b1;
          cnt_next          = cnt_inc;
          if (cnt_inc >= QUANT_SIZE) begin
            tables_next = tables_dec;
            phase_next  = (tables_dec != 8'd0) ? PH_DQT_HEAD : PH_SCAN;
          end
        end
        PH_SOF_SKIP: begin
          cnt_next = cnt_inc;
          if (cnt_inc >= SOF_SKIP) begin
            cnt_next   = '0;
            len_next   = '0;
            phase_next = PH_SOF_H;
          end
        end
        PH_SOF_H, PH_SOF_W: begin
          len_next = len_shift;
          cnt_next = cnt_inc;
          if (cnt_inc >= LEN_BYTES) begin
            res_c.kind  = (phase == PH_SOF_H) ? KIND_HEIGHT : KIND_WIDTH;
            res_c.value = len_shift;
            res_v       = 1'b1;
            cnt_next    = '0;
            len_next    = '0;
            phase_next  = (phase == PH_SOF_H) ? PH_SOF_W : PH_SOF_COUNT;
          end
        end
        PH_SOF_COUNT: begin
          ctot_next   = b;
          ccnt_next   = '0;
          cnt_next    = '0;
          res_c.kind  = KIND_FRAME_COUNT;
          res_c.value = {8'd0, b};
          res_v       = 1'b1;
          phase_next  = (b != 8'd0) ? PH_SOF_COMP : PH_SCAN;
        end
        PH_SOF_COMP: begin
          if (cnt == 12'd0) begin
            held_next = {b, 8'd0};
            cnt_next  = 12'd1;
          end else if (cnt == 12'd1) begin
            held_next = {held[15:8], b};
            cnt_next  = 12'd2;
          end else begin
            res_c.kind         = KIND_FRAME_COMP;
            res_c.position     = {4'd0, ccnt};
            res_c.comp_id      = held[15:8];
            res_c.factor_h     = held[7:4];
            res_c.factor_v     = held[3:0];
            res_c.quant_select = b;
            res_v              = 1'b1;
            ccnt_next          = ccnt_inc;
            cnt_next           = '0;
            if (ccnt_inc == ctot) phase_next = PH_SCAN;
          end
        end
        PH_DHT_LEN: begin
          len_next = len_shift;
          cnt_next = cnt_inc;
          if (cnt_inc >= LEN_BYTES) phase_next = PH_DHT_HEAD;
        end
        PH_DHT_HEAD: begin
          cls_next   = b[4];
          idx_next   = b[3:0];
          sym_next   = '0;
          cnt_next   = '0;
          phase_next = PH_DHT_COUNT;
        end
        PH_DHT_COUNT: begin
          res_c.kind        = KIND_HUFF_COUNT;
          res_c.table_class = cls;
          res_c.table_index = idx;
          res_c.position    = cnt;
          res_c.value       = {8'd0, b};
          res_v             = 1'b1;
          sym_next          = sym_sum;
          cnt_next          = cnt_inc;
          if (cnt_inc >= HUFF_COUNTS) begin
            cnt_next   = '0;
            phase_next = (sym_sum != 12'd0) ? PH_DHT_SYM : PH_DHT_END;
          end
        end
        PH_DHT_SYM: begin
          res_c.kind        = KIND_HUFF_SYMBOL;
          res_c.table_class = cls;
          res_c.table_index = idx;
          res_c.position    = cnt;
          res_c.value       = {8'd0, b};
          res_v             = 1'b1;
          cnt_next          = cnt_inc;
          if (cnt_inc >= sym) phase_next = PH_DHT_END;
        end
        PH_DHT_END: begin
          // checked on the byte after the section; a passing byte is rescanned
          if ({1'b0, len} != ({5'd0, sym} + DHT_FIXED)) begin
            res_c.kind       = KIND_ERROR;
            res_c.error_code = ERR_DHT_LEN;
            res_v            = 1'b1;
            halted_next      = 1'b1;
          end else begin
            res_c.kind        = KIND_HUFF_DONE;
            res_c.table_class = cls;
            res_c.table_index = idx;
            res_c.value       = {4'd0, sym};
            res_v             = 1'b1;
            phase_next        = (b == MARK_PREFIX) ? PH_MARKER : PH_SCAN;
          end
        end
        PH_SOS_LEN: begin
          cnt_next = cnt_inc;
          if (cnt_inc >= LEN_BYTES) phase_next = PH_SOS_COUNT;
        end
        PH_SOS_COUNT: begin
          ctot_next   = b;
          ccnt_next   = '0;
          cnt_next    = '0;
          res_c.kind  = KIND_SCAN_COUNT;
          res_c.value = {8'd0, b};
          res_v       = 1'b1;
          phase_next  = (b != 8'd0) ? PH_SOS_COMP : PH_SOS_TAIL;
        end
        PH_SOS_COMP: begin
          if (cnt == 12'd0) begin
            held_next = {8'd0, b};
            cnt_next  = 12'd1;
          end else begin
            res_c.kind     = KIND_SCAN_COMP;
            res_c.position = {4'd0, ccnt};
            res_c.comp_id  = held[7:0];
            res_c.dc_table = b[7:4];
            res_c.ac_table = b[3:0];
            res_v          = 1'b1;
            ccnt_next      = ccnt_inc;
            cnt_next       = '0;
            if (ccnt_inc == ctot) phase_next = PH_SOS_TAIL;
          end
        end
        PH_SOS_TAIL: begin
          cnt_next = cnt_inc;
          if (cnt_inc >= SOS_TAIL) begin
            res_c.kind = KIND_HEADER_DONE;
            res_v      = 1'b1;
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = PH_SCAN;
        end
      endcase
    end
  end

  // A byte moves on unless its result would overwrite one still waiting
  assign advance = stage.valid && (!res_v || !out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SCAN;
      len    <= '0;
      cnt    <= '0;
      tables <= '0;
      idx    <= '0;
      cls    <= 1'b0;
      sym    <= '0;
      ctot   <= '0;
      ccnt   <= '0;
      held   <= '0;
      halted <= 1'b0;
    end else if (advance) begin
      phase  <= phase_next;
      len    <= len_next;
      cnt    <= cnt_next;
      tables <= tables_next;
      idx    <= idx_next;
      cls    <= cls_next;
      sym    <= sym_next;
      ctot   <= ctot_next;
      ccnt   <= ccnt_next;
      held   <= held_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_v) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      res_q <= res_c;
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = res_q.kind;
  assign result.table_class  = res_q.table_class;
  assign result.table_index  = res_q.table_index;
  assign result.position     = res_q.position;
  assign result.value        = res_q.value;
  assign result.comp_id      = res_q.comp_id;
  assign result.factor_h     = res_q.factor_h;
  assign result.factor_v     = res_q.factor_v;
  assign result.quant_select = res_q.quant_select;
  assign result.dc_table     = res_q.dc_table;
  assign result.ac_table     = res_q.ac_table;
  assign result.error_code   = res_q.error_code;

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (halted || phase == PH_DONE) |-> !(advance && res_v))
    else $error("result produced after halt or header end");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (advance && res_v && res_c.kind == KIND_ERROR) |=> halted)
    else $error("error result without halt");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("left header-done state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !(advance && res_v))
    else $error("waiting result overwritten");

endmodule
